// ===== hdl/plen_pkg.sv =====
package plen_pkg;

  // Depth of the segment queue between front and back
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_PTR_BITS = 1;
  localparam int unsigned Q_CNT_BITS = 2;

  // Classification of one point, carried with its coordinate deltas
  typedef struct packed {
    logic has_seg;   // a previous point exists, so a segment is measured
    logic last;      // point closes the path
  } seg_flags_t;

endpackage

// ===== hdl/plen_front.sv =====
module plen_front import plen_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  final_point,
  input  logic                  point_valid,
  output logic                  point_ready,
  output logic                  seg_valid,
  input  logic                  seg_ready,
  output logic [COORD_BITS-1:0] seg_dx,
  output logic [COORD_BITS-1:0] seg_dy,
  output seg_flags_t            seg_flags
);

  localparam int D = COORD_BITS;

  logic [D-1:0] prev_x;
  logic [D-1:0] prev_y;
  logic         have_prev;

  logic [D:0]   diff_x;
  logic [D:0]   diff_y;
  logic [D:0]   neg_x;
  logic [D:0]   neg_y;
  logic         push;

  // Take a word whenever the queue has room
  assign point_ready = seg_ready;
  assign seg_valid   = point_valid;
  assign push        = point_valid && seg_ready;

  // Form absolute coordinate differences against the previous point
  always_comb begin
    diff_x = {point_x[D-1], point_x} - {prev_x[D-1], prev_x};
    diff_y = {point_y[D-1], point_y} - {prev_y[D-1], prev_y};
    neg_x  = (D+1)'(0) - diff_x;
    neg_y  = (D+1)'(0) - diff_y;
    seg_dx = diff_x[D] ? neg_x[D-1:0] : diff_x[D-1:0];
    seg_dy = diff_y[D] ? neg_y[D-1:0] : diff_y[D-1:0];
    seg_flags.has_seg = have_prev;
    seg_flags.last    = final_point;
  end

  // Hold the previous point; drop it at the end of a path
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (push) begin
      prev_x    <= point_x;
      prev_y    <= point_y;
      have_prev <= !final_point;
    end
  end

endmodule

// ===== hdl/plen_queue.sv =====
module plen_queue import plen_pkg::*; #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  input  seg_flags_t       wr_flags,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data,
  output seg_flags_t       rd_flags
);

  logic [WIDTH-1:0]      data_q  [Q_DEPTH];
  seg_flags_t            flags_q [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign wr_ready = (count != Q_CNT_BITS'(Q_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = data_q[rd_ptr];
  assign rd_flags = flags_q[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      data_q[wr_ptr]  <= wr_data;
      flags_q[wr_ptr] <= wr_flags;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/plen_back.sv =====
module plen_back import plen_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int TOTAL_BITS = 36
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seg_valid,
  output logic                  seg_ready,
  input  logic [COORD_BITS-1:0] seg_dx,
  input  logic [COORD_BITS-1:0] seg_dy,
  input  seg_flags_t            seg_flags,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [TOTAL_BITS-1:0] total_length,
  output logic                  overflowed
);

  localparam int D    = COORD_BITS;
  localparam int N    = D + 1;                  // root bits
  localparam int RW   = 2 * N;                  // radicand bits
  localparam int REMW = N + 2;                  // trial remainder bits
  localparam int SW   = ((TOTAL_BITS > N) ? TOTAL_BITS : N) + 1;
  localparam int CNTW = $clog2(N);

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQX,
    B_SQY,
    B_ROOT,
    B_ACC
  } back_state_t;

  back_state_t          state;
  logic [D-1:0]         dx;
  logic [D-1:0]         dy;
  logic                 is_last;
  logic [2*D-1:0]       sq_x;
  logic [RW-1:0]        rad;
  logic [N:0]           rem;
  logic [N-1:0]         root;
  logic [CNTW-1:0]      cnt;
  logic [TOTAL_BITS-1:0] total;
  logic                 sat_flag;

  logic [D-1:0]         mul_a;
  logic [2*D-1:0]       prod;
  logic [REMW-1:0]      rem_sh;
  logic [REMW-1:0]      trial;
  logic [REMW-1:0]      rem_sub;
  logic                 take_bit;
  logic [SW-1:0]        sum;
  logic                 sat_now;
  logic [TOTAL_BITS-1:0] total_next;
  logic                 sat_next;
  logic                 out_free;
  logic                 emit;

  // Pop a word only when idle
  assign seg_ready = (state == B_IDLE);
  assign out_free  = !result_valid || result_ready;
  assign emit      = (state == B_ACC) && is_last && out_free;

  // Shared squarer
  always_comb begin
    mul_a = (state == B_SQX) ? dx : dy;
    prod  = (2*D)'(mul_a) * (2*D)'(mul_a);
  end

  // One root bit per cycle
  always_comb begin
    rem_sh   = {rem[N-1:0], rad[RW-1:RW-2]};
    trial    = {root, 2'b01};
    take_bit = (rem_sh >= trial);
    rem_sub  = rem_sh - trial;
  end

  // Saturating accumulate
  always_comb begin
    sum        = SW'(total) + SW'(root);
    sat_now    = (sum > SW'({TOTAL_BITS{1'b1}}));
    total_next = sat_now ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
    sat_next   = sat_flag || sat_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      total        <= '0;
      sat_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !emit) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (seg_valid) begin
            dx      <= seg_dx;
            dy      <= seg_dy;
            is_last <= seg_flags.last;
            if (seg_flags.has_seg) begin
              state <= B_SQX;
            end else begin
              root  <= '0;
              state <= B_ACC;
            end
          end
        end
        B_SQX: begin
          sq_x  <= prod;
          state <= B_SQY;
        end
        B_SQY: begin
          rad   <= RW'(sq_x) + RW'(prod);
          rem   <= '0;
          root  <= '0;
          cnt   <= CNTW'(N - 1);
          state <= B_ROOT;
        end
        B_ROOT: begin
          rad  <= {rad[RW-3:0], 2'b00};
          rem  <= take_bit ? rem_sub[N:0] : rem_sh[N:0];
          root <= {root[N-2:0], take_bit};
          if (cnt == '0) begin
            state <= B_ACC;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        B_ACC: begin
          if (!is_last) begin
            total    <= total_next;
            sat_flag <= sat_next;
            state    <= B_IDLE;
          end else if (emit) begin
            total_length <= total_next;
            overflowed   <= sat_next;
            result_valid <= 1'b1;
            total        <= '0;
            sat_flag     <= 1'b0;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/polyline_length_accumulator.sv =====
// Flow: a point is written to the segment queue, popped when the back end is idle, squared
//   in x and then y on one multiplier, passed through a bit-serial square root of
//   COORD_BITS + 1 bits and accumulated; a path's first point skips the measurement.
// Overlap: the back end takes a new segment only when idle, and holds a closing segment
//   while a result word waits; two more points wait in the queue before input stalls.
// Reset: synchronous, active high; clears previous point, total, flag and queue.
module polyline_length_accumulator import plen_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int TOTAL_BITS = 36
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  final_point,
  input  logic                  point_valid,
  output logic                  point_ready,
  output logic [TOTAL_BITS-1:0] total_length,
  output logic                  overflowed,
  output logic                  result_valid,
  input  logic                  result_ready
);

  logic                    fq_valid;
  logic                    fq_ready;
  logic [COORD_BITS-1:0]   fq_dx;
  logic [COORD_BITS-1:0]   fq_dy;
  seg_flags_t              fq_flags;
  logic                    qb_valid;
  logic                    qb_ready;
  logic [2*COORD_BITS-1:0] qb_data;
  seg_flags_t              qb_flags;

  // Accept and classify points
  plen_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .point_x    (point_x),
    .point_y    (point_y),
    .final_point(final_point),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .seg_valid  (fq_valid),
    .seg_ready  (fq_ready),
    .seg_dx     (fq_dx),
    .seg_dy     (fq_dy),
    .seg_flags  (fq_flags)
  );

  // Buffer segments
  plen_queue #(
    .WIDTH(2 * COORD_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_data ({fq_dx, fq_dy}),
    .wr_flags(fq_flags),
    .rd_valid(qb_valid),
    .rd_ready(qb_ready),
    .rd_data (qb_data),
    .rd_flags(qb_flags)
  );

  // Measure and accumulate
  plen_back #(
    .COORD_BITS(COORD_BITS),
    .TOTAL_BITS(TOTAL_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .seg_valid   (qb_valid),
    .seg_ready   (qb_ready),
    .seg_dx      (qb_data[2*COORD_BITS-1:COORD_BITS]),
    .seg_dy      (qb_data[COORD_BITS-1:0]),
    .seg_flags   (qb_flags),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .total_length(total_length),
    .overflowed  (overflowed)
  );

`ifndef SYNTHESIS
  // A saturated total reads as all ones
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflowed) |-> (&total_length))
    else $error("overflowed set without saturated total");

  // No result word right after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Hold a waiting result word steady until it is taken
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(total_length)
      && $stable(overflowed)))
    else $error("result word changed while waiting");
`endif

endmodule

// ===== test/tb_polyline_length_accumulator.sv =====
`timescale 1ns / 1ps

module tb_polyline_length_accumulator;

  localparam int COORD_BITS   = 24;
  localparam int TOTAL_BITS   = 36;
  localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_BITS) - 1;
  localparam int SEG_CYCLES   = COORD_BITS + 5;
  localparam int DRAIN_CYCLES = 2 * SEG_CYCLES + 8;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLDOFF      = 400;
  localparam int RAND_POINTS  = 880;
  localparam int LONG_POINTS  = 200;
  localparam int TAIL_POINTS  = 150;
  localparam int SHOW_ERRORS  = 10;

  localparam logic [COORD_BITS-1:0] C_MIN  = 24'h800000;
  localparam logic [COORD_BITS-1:0] C_MAX  = 24'h7FFFFF;
  localparam logic [COORD_BITS-1:0] C_NEG1 = 24'hFFFFFF;

  typedef enum int {WALK_FULL, WALK_LOCAL, WALK_CORNER, WALK_MIXED} walk_t;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  fin;
  } point_t;

  typedef struct {
    logic [TOTAL_BITS-1:0] len;
    logic                  ovf;
  } path_total_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [COORD_BITS-1:0] point_x = '0;
  logic [COORD_BITS-1:0] point_y = '0;
  logic                  final_point = 1'b0;
  logic                  point_valid = 1'b0;
  logic                  point_ready;
  logic [TOTAL_BITS-1:0] total_length;
  logic                  overflowed;
  logic                  result_valid;
  logic                  result_ready = 1'b0;

  // points waiting to be offered, and path totals waiting to arrive
  point_t      points_q[$];
  path_total_t totals_q[$];

  // path state as the block should hold it
  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;
  logic                         have_last;
  logic [TOTAL_BITS-1:0]        path_sum;
  logic                         path_sat;

  bit     in_taken;
  bit     last_fill;
  bit     holdoff_armed;
  bit     holdoff_done;
  int     holdoff_left;
  int     send_gap;
  int     send_calm;
  int     take_gap;
  int     take_calm;
  int     quiet_cycles;
  int     errors;
  int     points_sent;
  int     paths_closed;
  int     paths_saturated;
  point_t nxt;

  polyline_length_accumulator #(
    .COORD_BITS(COORD_BITS),
    .TOTAL_BITS(TOTAL_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .point_x     (point_x),
    .point_y     (point_y),
    .final_point (final_point),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .total_length(total_length),
    .overflowed  (overflowed),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor of the square root, bit by bit from the top
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // add the segment from the previous point, emit the total on a final point
  task automatic measure_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                               logic fin);
    longint          dx;
    longint          dy;
    longint unsigned seg;
    logic [TOTAL_BITS:0] sum;
    path_total_t     res;
    if (have_last) begin
      dx = longint'($signed(x)) - longint'(last_x);
      dy = longint'($signed(y)) - longint'(last_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      seg = root_floor(longint'(dx * dx) + longint'(dy * dy));
      sum = {1'b0, path_sum} + seg[TOTAL_BITS:0];
      if (sum > TOTAL_MAX) begin
        path_sum = TOTAL_MAX[TOTAL_BITS-1:0];
        path_sat = 1'b1;
      end else begin
        path_sum = sum[TOTAL_BITS-1:0];
      end
    end
    last_x    = x;
    last_y    = y;
    have_last = 1'b1;
    if (fin) begin
      res.len = path_sum;
      res.ovf = path_sat;
      totals_q.push_back(res);
      if (path_sat) paths_saturated++;
      last_x    = '0;
      last_y    = '0;
      have_last = 1'b0;
      path_sum  = '0;
      path_sat  = 1'b0;
    end
  endtask

  task automatic flag_error(string what, longint unsigned want, longint unsigned got);
    errors++;
    if (errors <= SHOW_ERRORS)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic push_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                            logic fin);
    point_t p;
    p.x   = x;
    p.y   = y;
    p.fin = fin;
    points_q.push_back(p);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_corner();
    case ($urandom_range(0, 4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return C_NEG1;
      default: return 24'd1;
    endcase
  endfunction

  function automatic bit tail_calm();
    return last_fill && points_q.size() < TAIL_POINTS;
  endfunction

  // hold until every queued point is taken and every total has come back
  task automatic wait_idle();
    while (points_q.size() != 0 || point_valid || totals_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sample both handshakes, predict on input words, check output words
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && point_ready) begin
        measure_point(point_x, point_y, final_point);
        points_sent++;
        in_taken = 1'b1;
      end
      if (result_valid && result_ready) begin
        paths_closed++;
        if (totals_q.size() == 0) begin
          flag_error("unexpected total_length", 0, total_length);
        end else begin
          if (total_length !== totals_q[0].len)
            flag_error("total_length", totals_q[0].len, total_length);
          if (overflowed !== totals_q[0].ovf)
            flag_error("overflowed", totals_q[0].ovf, overflowed);
          void'(totals_q.pop_front());
        end
      end
    end
  end

  // end the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (point_valid && point_ready) || (result_valid && result_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d totals outstanding",
               STALL_LIMIT, totals_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // point driver: advance to the next word once the current one is taken
  always @(negedge clk) begin
    if (!rst && (in_taken || !point_valid)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        point_valid <= 1'b0;
      end else if (points_q.size() == 0) begin
        point_valid <= 1'b0;
      end else if (!tail_calm() && send_calm == 0 && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        point_valid <= 1'b0;
      end else begin
        nxt = points_q.pop_front();
        point_x     <= nxt.x;
        point_y     <= nxt.y;
        final_point <= nxt.fin;
        point_valid <= 1'b1;
      end
    end
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(40, 200);
  end

  // result sink: random stalls, plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      result_ready <= 1'b0;
    end else if (holdoff_armed && !holdoff_done) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF - 1;
      result_ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      result_ready <= 1'b0;
    end else if (!tail_calm() && take_calm == 0 && $urandom_range(0, 4) == 0) begin
      take_gap = $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
    if (take_calm > 0) take_calm--;
    else if ($urandom_range(0, 99) == 0) take_calm = $urandom_range(40, 200);
  end

  initial begin
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    walk_t                 walk;
    int                    len;
    int                    span;
    int                    added;

    last_x    = '0;
    last_y    = '0;
    have_last = 1'b0;
    path_sum  = '0;
    path_sat  = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single-point paths, extreme spans, zero and exact lengths
    push_point('0, '0, 1'b1);
    push_point(C_MAX, C_MIN, 1'b1);
    push_point(C_MIN, C_MIN, 1'b0);
    push_point(C_MAX, C_MAX, 1'b1);
    push_point('0, '0, 1'b0);
    push_point('0, '0, 1'b0);
    push_point('0, '0, 1'b1);
    push_point(C_MAX, '0, 1'b0);
    push_point(C_MIN, '0, 1'b1);
    push_point('0, C_MIN, 1'b0);
    push_point('0, C_MAX, 1'b1);
    push_point('0, '0, 1'b0);
    push_point(24'd768, 24'd1024, 1'b1);
    push_point(C_NEG1, C_NEG1, 1'b0);
    push_point(24'd1, 24'd1, 1'b1);
    push_point(24'd1, '0, 1'b0);
    push_point('0, 24'd1, 1'b0);
    push_point(C_NEG1, '0, 1'b0);
    push_point('0, C_NEG1, 1'b1);
    push_point(24'h555555, 24'hAAAAAA, 1'b0);
    push_point(24'hAAAAAA, 24'h555555, 1'b1);
    wait_idle();

    // one long path of full diagonals drives the total into the billions
    for (int i = 0; i < LONG_POINTS; i++) begin
      if (i % 2 == 0) push_point(C_MIN, C_MIN, i == LONG_POINTS - 1);
      else            push_point(C_MAX, C_MAX, i == LONG_POINTS - 1);
    end
    push_point(24'd123, 24'd456, 1'b1);
    wait_idle();

    // random paths, mostly short, each closed by a final point
    holdoff_armed = 1'b1;
    added = 0;
    while (added < RAND_POINTS) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      walk = walk_t'($urandom_range(0, 3));
      ox   = COORD_BITS'($urandom());
      oy   = COORD_BITS'($urandom());
      span = 1 << $urandom_range(0, 14);
      for (int k = 0; k < len; k++) begin
        case (walk)
          WALK_FULL: begin
            ox = COORD_BITS'($urandom());
            oy = COORD_BITS'($urandom());
          end
          WALK_LOCAL: begin
            ox = COORD_BITS'(ox + $urandom_range(0, 2 * span) - span);
            oy = COORD_BITS'(oy + $urandom_range(0, 2 * span) - span);
          end
          WALK_CORNER: begin
            ox = pick_corner();
            oy = pick_corner();
          end
          default: begin
            ox = pick_corner();
            oy = COORD_BITS'($urandom());
          end
        endcase
        push_point(ox, oy, k == len - 1);
      end
      added += len;
    end
    last_fill = 1'b1;
    wait_idle();

    $display("sent %0d points over %0d paths, including extreme spans and one long path;",
             points_sent, paths_closed);
    $display("%0d paths saturated the total, %0d mismatches found",
             paths_saturated, errors);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/plen_pkg.sv
hdl/plen_front.sv
hdl/plen_queue.sv
hdl/plen_back.sv
hdl/polyline_length_accumulator.sv
test/tb_polyline_length_accumulator.sv
